>>> rtl/pidh_pkg.sv
// shared types and constants for the heater pid controller
// no dependencies

package pidh_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_SETPOINT  = 3'd0;
    localparam logic [2:0] CFG_GAIN_P    = 3'd1;
    localparam logic [2:0] CFG_GAIN_I    = 3'd2;
    localparam logic [2:0] CFG_GAIN_D    = 3'd3;
    localparam logic [2:0] CFG_PERIOD    = 3'd4;

    // register reset values
    localparam logic signed [15:0] SETPOINT_RST = 16'sd11520;
    localparam logic [15:0] GAIN_P_RST = 16'd35200;
    localparam logic [15:0] GAIN_I_RST = 16'd19;
    localparam logic [15:0] GAIN_D_RST = 16'd28800;
    localparam logic [15:0] PERIOD_RST = 16'd0;

    // drive to compare mapping
    localparam int SUM_FRAC   = 15;
    localparam int SUM_W      = 50;
    localparam logic [13:0] DRIVE_LIMIT   = 14'd9728;
    localparam logic [13:0] DRIVE_REPLACE = 14'd9472;
    localparam logic [13:0] COMPARE_TOP   = 14'h2600;
    localparam logic [13:0] COMPARE_MAX   = 14'h2500;
    localparam logic [13:0] COMPARE_MIN   = 14'd10;

    // widths of the product stage
    localparam int PROD_P_W = 34;
    localparam int PROD_I_W = 49;
    localparam int PROD_D_W = 35;

    typedef struct packed {
        logic signed [PROD_P_W-1:0] prod_p;
        logic signed [PROD_I_W-1:0] prod_i;
        logic signed [PROD_D_W-1:0] prod_d;
    } pidh_prod_t;

endpackage

>>> rtl/pidh_drive_map.sv
// sums the gain products and maps the drive onto a timer compare value
// depends on pidh_pkg

module pidh_drive_map (
    input  pidh_pkg::pidh_prod_t prod,
    output logic [13:0]          compare
);

    localparam logic signed [pidh_pkg::SUM_W-1:0] SUM_LIMIT =
        pidh_pkg::SUM_W'(pidh_pkg::DRIVE_LIMIT) <<< pidh_pkg::SUM_FRAC;

    logic signed [pidh_pkg::SUM_W-1:0] sum;
    logic [13:0] drive;
    logic [13:0] raw_cmp;

    always_comb begin
        sum = (pidh_pkg::SUM_W'(prod.prod_p) <<< 1)
            + pidh_pkg::SUM_W'(prod.prod_i)
            + (pidh_pkg::SUM_W'(prod.prod_d) <<< 1);

        priority if (sum > SUM_LIMIT) begin
            drive = pidh_pkg::DRIVE_REPLACE;
        end else if (sum < 0) begin
            drive = 14'd0;
        end else begin
            // sum is at most the limit here, so the drive fits in 14 bits
            drive = sum[pidh_pkg::SUM_FRAC +: 14];
        end

        raw_cmp = pidh_pkg::COMPARE_TOP - drive;

        priority if (raw_cmp < pidh_pkg::COMPARE_MIN) begin
            compare = pidh_pkg::COMPARE_MIN;
        end else if (raw_cmp > pidh_pkg::COMPARE_MAX) begin
            compare = pidh_pkg::COMPARE_MAX;
        end else begin
            compare = raw_cmp;
        end
    end

endmodule

>>> rtl/pid_heater_pwm_control.sv
// heater pid controller, taking one input beat per cycle while m_ready does not stall
// the pipe; beats whose count misses the period give no result
// four register stages (input, error/integral, products, compare) with per-stage
// valids, so bubbles close up and input is taken while a result waits
// synchronous active-low reset clears valids, error history, integral and
// loads the configuration defaults; depends on pidh_pkg and pidh_drive_map

module pid_heater_pwm_control (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration write port
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // input beats
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_ms_count,
    input  logic signed [15:0] s_measured_temp,
    // result beats
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_pwm_compare
);

    // configuration registers
    logic signed [15:0] setpoint_reg;
    logic [15:0]        gain_p_reg;
    logic [15:0]        gain_i_reg;
    logic [15:0]        gain_d_reg;
    logic [15:0]        period_reg;

    // controller state
    logic signed [16:0] prev_err_reg;
    logic signed [31:0] integral_reg;

    // stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    // stage enables: a stage loads when empty or when it drains downstream
    logic en0, en1, en2, en3;

    // stage 0: captured input beat
    logic [15:0]        cnt0_reg;
    logic signed [15:0] meas0_reg;

    // stage 1: error terms
    logic signed [16:0] err1_reg;
    logic signed [17:0] diff1_reg;
    logic signed [31:0] int1_reg;

    // stage 2: gain products
    pidh_pkg::pidh_prod_t prod2_reg;
    pidh_pkg::pidh_prod_t prod2_next;

    // stage 3: result register
    logic [13:0] cmp3_reg;
    logic [13:0] cmp3_next;

    // stage 0 -> 1 math
    logic               match;
    logic signed [16:0] err_next;
    logic signed [17:0] diff_next;
    logic signed [33:0] acc;
    logic signed [31:0] integral_next;
    logic               update;

    assign en3 = !v3_reg || m_ready;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign en0 = !v0_reg || en1;
    assign s_ready = en0;

    assign m_valid       = v3_reg;
    assign m_pwm_compare = cmp3_reg;

    // error, trapezoidal integral with 32-bit saturation, derivative difference
    always_comb begin
        match     = (cnt0_reg == period_reg);
        err_next  = 17'(setpoint_reg) - 17'(meas0_reg);
        diff_next = 18'(err_next) - 18'(prev_err_reg);
        acc       = 34'(integral_reg) + 34'(err_next) + 34'(prev_err_reg);
        // top three bits disagree means out of 32-bit signed range
        if (acc[33:31] == 3'b000 || acc[33:31] == 3'b111) begin
            integral_next = acc[31:0];
        end else if (acc[33]) begin
            integral_next = 32'sh8000_0000;
        end else begin
            integral_next = 32'sh7fff_ffff;
        end
        update = v0_reg && en1 && match;
    end

    // one multiplier per term, unsigned gains widened by a zero sign bit
    always_comb begin
        prod2_next.prod_p = $signed({1'b0, gain_p_reg}) * err1_reg;
        prod2_next.prod_i = $signed({1'b0, gain_i_reg}) * int1_reg;
        prod2_next.prod_d = $signed({1'b0, gain_d_reg}) * diff1_reg;
    end

    pidh_drive_map u_drive_map (
        .prod    (prod2_reg),
        .compare (cmp3_next)
    );

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            setpoint_reg <= pidh_pkg::SETPOINT_RST;
            gain_p_reg   <= pidh_pkg::GAIN_P_RST;
            gain_i_reg   <= pidh_pkg::GAIN_I_RST;
            gain_d_reg   <= pidh_pkg::GAIN_D_RST;
            period_reg   <= pidh_pkg::PERIOD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pidh_pkg::CFG_SETPOINT: setpoint_reg <= $signed(cfg_data);
                pidh_pkg::CFG_GAIN_P:   gain_p_reg   <= cfg_data;
                pidh_pkg::CFG_GAIN_I:   gain_i_reg   <= cfg_data;
                pidh_pkg::CFG_GAIN_D:   gain_d_reg   <= cfg_data;
                pidh_pkg::CFG_PERIOD:   period_reg   <= cfg_data;
                default: ; // unused indexes are dropped
            endcase
        end
    end

    // controller state only moves on a matching beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            integral_reg <= '0;
        end else if (update) begin
            prev_err_reg <= err_next;
            integral_reg <= integral_next;
        end
    end

    // stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en0) v0_reg <= s_valid;
            // mismatched beats are dropped here
            if (en1) v1_reg <= v0_reg && match;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (en0) begin
            cnt0_reg  <= s_ms_count;
            meas0_reg <= s_measured_temp;
        end
        if (en1) begin
            err1_reg  <= err_next;
            diff1_reg <= diff_next;
            int1_reg  <= integral_next;
        end
        if (en2) begin
            prod2_reg <= prod2_next;
        end
        if (en3) begin
            cmp3_reg <= cmp3_next;
        end
    end

endmodule

>>> tb/pidh_compare_monitor.sv
// pidh_compare_monitor: watches the config port and both beat channels, predicts
// pwm_compare per accepted input beat and checks result beats in order
// depends on pidh_pkg
`timescale 1ns / 100ps

module pidh_compare_monitor (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [15:0]        s_ms_count,
    input  logic signed [15:0] s_measured_temp,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [13:0]        m_pwm_compare,
    output int                 fail_count,
    output int                 pending
);

    localparam longint INTEG_MAX = longint'(32'sh7fff_ffff);
    localparam longint INTEG_MIN = longint'(32'sh8000_0000);
    localparam int     SHOWN_MAX = 10;

    // shadow copy of the registers and the controller state
    logic signed [15:0] target_r;
    logic [15:0]        kp_r;
    logic [15:0]        ki_r;
    logic [15:0]        kd_r;
    logic [15:0]        period_r;
    longint             last_err;
    longint             err_sum;

    logic [13:0] pending_compares[$];
    int          errors = 0;

    // one control update; returns 0 when the count misses the period
    function automatic bit predict_compare(input logic [15:0] count,
                                           input logic signed [15:0] temp,
                                           output logic [13:0] compare);
        longint err;
        longint acc;
        longint sum;
        longint drive;
        longint cmp;
        compare = '0;
        if (count != period_r)
            return 1'b0;
        err = longint'(target_r) - longint'(temp);
        acc = err_sum + err + last_err;
        if (acc > INTEG_MAX)
            acc = INTEG_MAX;
        if (acc < INTEG_MIN)
            acc = INTEG_MIN;
        err_sum = acc;
        sum = 2 * longint'(kp_r) * err
            + longint'(ki_r) * err_sum
            + 2 * longint'(kd_r) * (err - last_err);
        last_err = err;
        if (sum > (longint'(pidh_pkg::DRIVE_LIMIT) <<< pidh_pkg::SUM_FRAC))
            drive = longint'(pidh_pkg::DRIVE_REPLACE);
        else if (sum < 0)
            drive = 0;
        else
            drive = sum >>> pidh_pkg::SUM_FRAC;
        cmp = longint'(pidh_pkg::COMPARE_TOP) - drive;
        if (cmp < longint'(pidh_pkg::COMPARE_MIN))
            cmp = longint'(pidh_pkg::COMPARE_MIN);
        if (cmp > longint'(pidh_pkg::COMPARE_MAX))
            cmp = longint'(pidh_pkg::COMPARE_MAX);
        compare = cmp[13:0];
        return 1'b1;
    endfunction

    task automatic report(input string what, input logic [13:0] want, input logic [13:0] got);
        errors++;
        if (errors <= SHOWN_MAX)
            $display("%0t pwm_compare %s: expected %0d, got %0d", $realtime, what, want, got);
    endtask

    always @(posedge aclk) begin : watch
        logic [13:0] want;
        if (!aresetn) begin
            target_r = pidh_pkg::SETPOINT_RST;
            kp_r     = pidh_pkg::GAIN_P_RST;
            ki_r     = pidh_pkg::GAIN_I_RST;
            kd_r     = pidh_pkg::GAIN_D_RST;
            period_r = pidh_pkg::PERIOD_RST;
            last_err = 0;
            err_sum  = 0;
            pending_compares.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    pidh_pkg::CFG_SETPOINT: target_r = cfg_data;
                    pidh_pkg::CFG_GAIN_P:   kp_r = cfg_data;
                    pidh_pkg::CFG_GAIN_I:   ki_r = cfg_data;
                    pidh_pkg::CFG_GAIN_D:   kd_r = cfg_data;
                    pidh_pkg::CFG_PERIOD:   period_r = cfg_data;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (predict_compare(s_ms_count, s_measured_temp, want))
                    pending_compares.push_back(want);
            end
            if (m_valid && m_ready) begin
                if (pending_compares.size() == 0) begin
                    report("beat with nothing pending", '0, m_pwm_compare);
                end else begin
                    want = pending_compares.pop_front();
                    if (want !== m_pwm_compare)
                        report("mismatch", want, m_pwm_compare);
                end
            end
        end
        pending    <= pending_compares.size();
        fail_count <= errors;
    end

endmodule

>>> tb/pid_heater_pwm_control_tb.sv
// pid_heater_pwm_control_tb: drives config writes and input beats, randomizes
// output back-pressure, and reports the verdict from pidh_compare_monitor
// depends on pidh_pkg, pid_heater_pwm_control and pidh_compare_monitor
`timescale 1ns / 100ps

module pid_heater_pwm_control_tb;

    localparam int         LONG_HOLD   = 300;
    localparam int         DRAIN_EXTRA = 8;
    localparam int         RAND_SETS   = 6;
    localparam int         SET_BEATS   = 155;
    localparam int         CFG_COUNT   = 5;
    localparam logic [15:0] TEMP_MIN   = 16'h8000;
    localparam logic [15:0] TEMP_MAX   = 16'h7fff;
    localparam logic [15:0] WORD_MAX   = 16'hffff;

    // every input starts at a known value
    logic               aclk            = 1'b0;
    logic               aresetn         = 1'b0;
    logic               cfg_we          = 1'b0;
    logic [2:0]         cfg_index       = '0;
    logic [15:0]        cfg_data        = '0;
    logic               s_valid         = 1'b0;
    logic               s_ready;
    logic [15:0]        s_ms_count      = '0;
    logic signed [15:0] s_measured_temp = '0;
    logic               m_valid;
    logic               m_ready         = 1'b0;
    logic [13:0]        m_pwm_compare;

    int fail_count;
    int pending;

    // shared between the beat driver and the back-pressure process
    bit quiet        = 1'b0;   // no idling on either side
    bit hold_request = 1'b0;   // ask the receiver for one long hold

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    pid_heater_pwm_control u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ms_count      (s_ms_count),
        .s_measured_temp (s_measured_temp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_compare   (m_pwm_compare)
    );

    pidh_compare_monitor u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ms_count      (s_ms_count),
        .s_measured_temp (s_measured_temp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pwm_compare   (m_pwm_compare),
        .fail_count      (fail_count),
        .pending         (pending)
    );

    // one input beat; valid is left high so back-to-back beats never drop it
    task automatic send(input logic [15:0] count, input logic [15:0] temp);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            // idle burst of random length ahead of this beat
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_ms_count      <= count;
        s_measured_temp <= temp;
        do @(posedge aclk); while (!s_ready);
    endtask

    // stop offering beats and wait for every pending compare, plus the pipe
    // depth so beats that give no result have left the block too
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_EXTRA) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] index, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(posedge aclk);
    endtask

    // all five registers, then junk to the unused indexes, which must be ignored
    task automatic load_config(input logic [15:0] target, input logic [15:0] kp,
                               input logic [15:0] ki, input logic [15:0] kd,
                               input logic [15:0] period);
        write_reg(pidh_pkg::CFG_SETPOINT, target);
        write_reg(pidh_pkg::CFG_GAIN_P, kp);
        write_reg(pidh_pkg::CFG_GAIN_I, ki);
        write_reg(pidh_pkg::CFG_GAIN_D, kd);
        write_reg(pidh_pkg::CFG_PERIOD, period);
        for (int i = CFG_COUNT; i < 2 ** $bits(cfg_index); i++)
            write_reg(i[2:0], 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    // mostly near the setpoint so the drive lands in its linear range,
    // sometimes anywhere in the field
    function automatic logic [15:0] pick_temp(input logic [15:0] target, input int spread);
        logic [15:0] t;
        if ($urandom_range(0, 9) < 2)
            t = 16'($urandom);
        else
            t = 16'(target + spread - $urandom_range(0, 2 * spread));
        return t;
    endfunction

    // mostly a hit on the period, otherwise near misses and random counts
    function automatic logic [15:0] pick_count(input logic [15:0] period);
        logic [15:0] c;
        case ($urandom_range(0, 7))
            0: c = 16'($urandom);
            1: c = period + 16'd1;
            2: c = period - 16'd1;
            default: c = period;
        endcase
        return c;
    endfunction

    // receiver: random stall bursts, one long hold on request, none when quiet
    initial begin : sink
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 9)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [15:0] target;
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [15:0] period;
        int          spread;

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reset config: setpoint 45 degrees, period 0
        send(16'd0, pidh_pkg::SETPOINT_RST);            // zero error, zero drive
        send(16'd1, 16'd0);                             // count miss
        send(WORD_MAX, 16'd0);                          // count miss at the top count
        send(16'd0, TEMP_MIN);                          // huge drive, replaced
        send(16'd0, TEMP_MAX);                          // negative drive
        send(16'd0, pidh_pkg::SETPOINT_RST - 16'd1000);
        send(16'd0, pidh_pkg::SETPOINT_RST + 16'd500);
        send(16'd0, pidh_pkg::SETPOINT_RST - 16'd3000);
        send(16'd0, pidh_pkg::SETPOINT_RST);            // zero error, integral and derivative terms only
        drain();

        // all registers at their top values
        load_config(TEMP_MAX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
        send(WORD_MAX, TEMP_MIN);
        send(16'hfffe, 16'd0);
        send(WORD_MAX, TEMP_MAX);
        send(16'd0, 16'd0);
        drain();

        // lowest setpoint, zero gains
        load_config(TEMP_MIN, 16'd0, 16'd0, 16'd0, 16'h5a5a);
        send(16'h5a5a, TEMP_MAX);
        send(16'h5a5a, TEMP_MIN);
        send(16'ha5a5, 16'h5a5a);
        send(16'h5a5a, TEMP_MIN);             // error back to zero
        drain();

        // random settings; the last one runs without idling
        for (int setting = 0; setting < RAND_SETS; setting++) begin
            target = 16'($urandom);
            kp     = 16'($urandom_range(0, 65535) >> $urandom_range(0, 10));
            ki     = 16'($urandom_range(0, 65535) >> $urandom_range(4, 15));
            kd     = 16'($urandom_range(0, 65535) >> $urandom_range(0, 10));
            case (setting)
                0: period = 16'd0;
                2: period = WORD_MAX;
                default: period = 16'($urandom);
            endcase
            if (setting == 1) begin
                kp = pidh_pkg::GAIN_P_RST;
                ki = pidh_pkg::GAIN_I_RST;
                kd = pidh_pkg::GAIN_D_RST;
            end
            spread = 1 << $urandom_range(4, 13);
            drain();
            load_config(target, kp, ki, kd, period);
            // long receiver hold while beats keep coming, so the pipe backs up
            if (setting == 1)
                hold_request = 1'b1;
            if (setting == RAND_SETS - 1)
                quiet = 1'b1;
            repeat (SET_BEATS) send(pick_count(period), pick_temp(target, spread));
        end
        drain();

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin : watchdog
        #8_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
